[rtl/csc_pkg.sv]
`default_nettype none
package csc_pkg;

    localparam int MAX_DIM_DEF      = 256;
    localparam int MAX_NONZEROS_DEF = 4096;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int FRAC_BITS        = 16;

    localparam logic [2:0] OP_COLUMN = 3'd0;
    localparam logic [2:0] OP_ENTRY  = 3'd1;
    localparam logic [2:0] OP_VECTOR = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_RUN    = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic [2:0] REG_NUM_ROWS      = 3'd0;
    localparam logic [2:0] REG_NUM_COLUMNS   = 3'd1;
    localparam logic [2:0] REG_INDEX_OFFSET  = 3'd2;
    localparam logic [2:0] REG_TRANSPOSE     = 3'd3;
    localparam logic [2:0] REG_SUBTRACT      = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [11:0]        slot;
        logic [12:0]        pointer_value;
        logic [8:0]         row_number;
        logic signed [31:0] data_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               status;
        logic               saturated;
    } result_t;

endpackage
`default_nettype wire

[rtl/csc_sparse_matrix_vector_multiply.sv]
`default_nettype none
// channel   handshake                    payload
// item      start, accepted when !busy   item (csc_pkg::item_t)
// result    done, one cycle strobe       result (csc_pkg::result_t)
// config    apb write/read, pready = 1   paddr, pwdata, prdata
//
// load items and unused ops answer in the cycle after the transfer, reads via
// S_READ; a run steps each column through S_C0-S_C2 and S_E0, each stored entry
// through S_E0-S_E3 (S_E0-S_E1 for a skipped row), set by the read-modify-write
// of the sum memory via the multiplier; a clear and the reset pass sweep the sum
// memory; busy is high during all multi-cycle work; results cannot be stalled
module csc_sparse_matrix_vector_multiply #(
    parameter int MAX_DIM      = csc_pkg::MAX_DIM_DEF,
    parameter int MAX_NONZEROS = csc_pkg::MAX_NONZEROS_DEF,
    parameter int VALUE_WIDTH  = csc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire csc_pkg::item_t   item,
    output logic                  done,
    output csc_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IW  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int VW  = VALUE_WIDTH;
    localparam int CB  = $clog2(MAX_DIM + 1);
    localparam int DB  = $clog2(MAX_DIM);
    localparam int KW  = $clog2(MAX_NONZEROS + 1);
    localparam int EAW = $clog2(MAX_NONZEROS);
    localparam int EWD = 9 + IW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_C0, S_C1, S_C2, S_E0, S_E1, S_E2, S_E3
    } state_t;

    state_t             state_reg;
    logic [CB-1:0]      col_reg;
    logic [KW-1:0]      k_reg;
    logic [KW-1:0]      end_reg;
    logic [12:0]        start_reg;
    logic [DB-1:0]      clr_reg;
    logic               clr_op_reg;
    logic signed [IW-1:0] val_reg;
    logic [DB-1:0]      tgt_reg;
    logic signed [VW-1:0] acc_reg;
    logic               sat_reg;
    logic               done_reg;
    logic               done_next;
    csc_pkg::result_t   res_reg;
    logic [8:0]         num_rows_reg;
    logic [8:0]         num_columns_reg;
    logic               offset_reg;
    logic               transpose_reg;
    logic               subtract_reg;

    logic               accept;
    logic [31:0]        nr_eff;
    logic [31:0]        nc_eff;
    logic               col_we;
    logic               col_re;
    logic [CB-1:0]      col_raddr;
    logic [12:0]        col_rdata;
    logic               ent_we;
    logic               ent_re;
    logic [EWD-1:0]     ent_rdata;
    logic               vec_we;
    logic               vec_re;
    logic [DB-1:0]      vec_raddr;
    logic [IW-1:0]      vec_rdata;
    logic               sum_we;
    logic [DB-1:0]      sum_waddr;
    logic [VW-1:0]      sum_wdata;
    logic               sum_re;
    logic [DB-1:0]      sum_raddr;
    logic [VW-1:0]      sum_rdata;
    logic [8:0]         ent_row;
    logic signed [IW-1:0] ent_val;
    logic [9:0]         row_adj;
    logic               row_ok;
    logic signed [14:0] sv;
    logic signed [14:0] ev;
    logic [KW-1:0]      k_start;
    logic [KW-1:0]      k_end;
    logic signed [VW-1:0] mac_sum;
    logic               mac_sat;
    logic [CB-1:0]      col_inc;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
    assign pready = 1'b1;

    assign nr_eff  = (32'(num_rows_reg) < 32'(MAX_DIM)) ? 32'(num_rows_reg) : 32'(MAX_DIM);
    assign nc_eff  = (32'(num_columns_reg) < 32'(MAX_DIM)) ? 32'(num_columns_reg)
                                                           : 32'(MAX_DIM);
    assign col_inc = col_reg + CB'(1);

    assign ent_row = ent_rdata[EWD-1:IW];
    assign ent_val = ent_rdata[IW-1:0];
    assign row_adj = {1'b0, ent_row} - {9'd0, offset_reg};
    assign row_ok  = (ent_row >= {8'd0, offset_reg}) && (32'(row_adj) < nr_eff);

    assign sv = $signed({2'b00, start_reg}) - $signed({14'd0, offset_reg});
    assign ev = $signed({2'b00, col_rdata}) - $signed({14'd0, offset_reg});

    always_comb
    begin
        if (sv < 0)
            k_start = '0;
        else if (32'(sv) > 32'(MAX_NONZEROS))
            k_start = KW'(MAX_NONZEROS);
        else
            k_start = KW'(sv);
        if (ev < 0)
            k_end = '0;
        else if (32'(ev) > 32'(MAX_NONZEROS))
            k_end = KW'(MAX_NONZEROS);
        else
            k_end = KW'(ev);
    end

    // memory port selection
    always_comb
    begin
        col_we    = accept && (item.op == csc_pkg::OP_COLUMN)
                    && (32'(item.slot) <= 32'(MAX_DIM));
        col_re    = (state_reg == S_C0) || (state_reg == S_C1);
        col_raddr = (state_reg == S_C0) ? col_reg : col_inc;
        ent_we    = accept && (item.op == csc_pkg::OP_ENTRY)
                    && (32'(item.slot) < 32'(MAX_NONZEROS));
        ent_re    = (state_reg == S_E0) && (k_reg < end_reg);
        vec_we    = accept && (item.op == csc_pkg::OP_VECTOR)
                    && (32'(item.slot) < 32'(MAX_DIM));
        vec_re    = (state_reg == S_E1) && row_ok;
        vec_raddr = transpose_reg ? DB'(row_adj) : DB'(col_reg);
        sum_re    = vec_re || (accept && (item.op == csc_pkg::OP_READ));
        sum_raddr = (state_reg == S_E1) ? (transpose_reg ? DB'(col_reg) : DB'(row_adj))
                                        : DB'(item.slot);
        sum_we    = (state_reg == S_CLEAR) || (state_reg == S_E3);
        sum_waddr = (state_reg == S_CLEAR) ? clr_reg : tgt_reg;
        sum_wdata = (state_reg == S_CLEAR) ? '0 : VW'(mac_sum);
    end

    // result strobe
    always_comb
    begin
        done_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
                done_next = clr_op_reg && (clr_reg == DB'(MAX_DIM - 1));
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.op)
                        csc_pkg::OP_CLEAR: done_next = 1'b0;
                        csc_pkg::OP_RUN:   done_next = (nc_eff == 32'd0);
                        csc_pkg::OP_READ:  done_next = (32'(item.slot) >= 32'(MAX_DIM));
                        default:           done_next = 1'b1;
                    endcase
                end
            end
            S_READ:
                done_next = 1'b1;
            S_E0:
                done_next = (k_reg >= end_reg) && (32'(col_inc) == nc_eff);
            default:
                done_next = 1'b0;
        endcase
    end

    csc_ram #(.WIDTH(13), .DEPTH(MAX_DIM + 1)) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (CB'(item.slot)),
        .wdata (item.pointer_value),
        .re    (col_re),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    csc_ram #(.WIDTH(EWD), .DEPTH(MAX_NONZEROS)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (EAW'(item.slot)),
        .wdata ({item.row_number, IW'(item.data_value)}),
        .re    (ent_re),
        .raddr (k_reg[EAW-1:0]),
        .rdata (ent_rdata)
    );

    csc_ram #(.WIDTH(IW), .DEPTH(MAX_DIM)) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (DB'(item.slot)),
        .wdata (IW'(item.data_value)),
        .re    (vec_re),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    csc_ram #(.WIDTH(VW), .DEPTH(MAX_DIM)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    csc_mac #(.IW(IW), .VW(VW)) u_mac (
        .clk  (clk),
        .load (state_reg == S_E2),
        .a    (val_reg),
        .b    ($signed(vec_rdata)),
        .acc  (acc_reg),
        .sub  (subtract_reg),
        .sum  (mac_sum),
        .sat  (mac_sat)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= 9'd256;
            num_columns_reg <= 9'd256;
            offset_reg      <= 1'b0;
            transpose_reg   <= 1'b0;
            subtract_reg    <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                csc_pkg::REG_NUM_ROWS:     num_rows_reg    <= pwdata[8:0];
                csc_pkg::REG_NUM_COLUMNS:  num_columns_reg <= pwdata[8:0];
                csc_pkg::REG_INDEX_OFFSET: offset_reg      <= pwdata[0];
                csc_pkg::REG_TRANSPOSE:    transpose_reg   <= pwdata[0];
                csc_pkg::REG_SUBTRACT:     subtract_reg    <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            csc_pkg::REG_NUM_ROWS:     prdata = {23'd0, num_rows_reg};
            csc_pkg::REG_NUM_COLUMNS:  prdata = {23'd0, num_columns_reg};
            csc_pkg::REG_INDEX_OFFSET: prdata = {31'd0, offset_reg};
            csc_pkg::REG_TRANSPOSE:    prdata = {31'd0, transpose_reg};
            csc_pkg::REG_SUBTRACT:     prdata = {31'd0, subtract_reg};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= (state_reg == S_C1) ? col_rdata : start_reg;
        if (state_reg == S_E1)
        begin
            val_reg <= ent_val;
            tgt_reg <= sum_raddr;
        end
        if (state_reg == S_E2)
        begin
            acc_reg <= $signed(sum_rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            clr_op_reg <= 1'b0;
            col_reg    <= '0;
            k_reg      <= '0;
            end_reg    <= '0;
            sat_reg    <= 1'b0;
            done_reg   <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            done_reg <= done_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg == DB'(MAX_DIM - 1))
                    begin
                        state_reg  <= S_IDLE;
                        clr_reg    <= '0;
                        clr_op_reg <= 1'b0;
                        res_reg    <= '0;
                    end
                    else
                        clr_reg <= clr_reg + DB'(1);
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (item.op)
                            csc_pkg::OP_COLUMN:
                                res_reg <= '{read_value: '0, status: !col_we,
                                             saturated: sat_reg};
                            csc_pkg::OP_ENTRY:
                                res_reg <= '{read_value: '0, status: !ent_we,
                                             saturated: sat_reg};
                            csc_pkg::OP_VECTOR:
                                res_reg <= '{read_value: '0, status: !vec_we,
                                             saturated: sat_reg};
                            csc_pkg::OP_CLEAR:
                            begin
                                sat_reg    <= 1'b0;
                                clr_op_reg <= 1'b1;
                                state_reg  <= S_CLEAR;
                            end
                            csc_pkg::OP_RUN:
                            begin
                                col_reg <= '0;
                                res_reg <= '{read_value: '0, status: 1'b0, saturated: sat_reg};
                                if (nc_eff != 32'd0)
                                    state_reg <= S_C0;
                            end
                            csc_pkg::OP_READ:
                            begin
                                res_reg <= '{read_value: '0,
                                             status: (32'(item.slot) >= 32'(MAX_DIM)),
                                             saturated: sat_reg};
                                if (32'(item.slot) < 32'(MAX_DIM))
                                    state_reg <= S_READ;
                            end
                            default:
                                res_reg <= '{read_value: '0, status: 1'b0, saturated: sat_reg};
                        endcase
                    end
                end
                S_READ:
                begin
                    res_reg.read_value <= 32'($signed(sum_rdata));
                    state_reg          <= S_IDLE;
                end
                S_C0:
                    state_reg <= S_C1;
                S_C1:
                    state_reg <= S_C2;
                S_C2:
                begin
                    k_reg     <= k_start;
                    end_reg   <= k_end;
                    state_reg <= S_E0;
                end
                S_E0:
                begin
                    if (k_reg < end_reg)
                        state_reg <= S_E1;
                    else if (32'(col_inc) == nc_eff)
                    begin
                        res_reg   <= '{read_value: '0, status: 1'b0, saturated: sat_reg};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        col_reg   <= col_inc;
                        state_reg <= S_C0;
                    end
                end
                S_E1:
                begin
                    if (row_ok)
                        state_reg <= S_E2;
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_E0;
                    end
                end
                S_E2:
                    state_reg <= S_E3;
                S_E3:
                begin
                    sat_reg   <= sat_reg | mac_sat;
                    k_reg     <= k_reg + KW'(1);
                    state_reg <= S_E0;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == csc_pkg::OP_COLUMN || item.op == csc_pkg::OP_ENTRY
         || item.op == csc_pkg::OP_VECTOR)) |=> done)
        else $error("load transfer gave no result");

    a_sum_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_E3) |-> $past(state_reg == S_E2))
        else $error("sum write without product");
`endif

endmodule
`default_nettype wire

[rtl/csc_ram.sv]
`default_nettype none
module csc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/csc_mac.sv]
`default_nettype none
module csc_mac #(
    parameter int IW = 32,
    parameter int VW = 32
) (
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic signed [IW-1:0] a,
    input  wire logic signed [IW-1:0] b,
    input  wire logic signed [VW-1:0] acc,
    input  wire logic                 sub,
    output logic signed [VW-1:0]      sum,
    output logic                      sat
);

    localparam int PW = 2 * IW;
    localparam int EW = ((PW > VW) ? PW : VW) + 2;
    localparam logic signed [EW-1:0] SMAX = {{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = ~SMAX;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] shifted;
    logic signed [EW-1:0] total;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= a * b;
        end
    end

    always_comb
    begin
        shifted = prod_reg >>> csc_pkg::FRAC_BITS;
        total = sub ? (EW'(acc) - EW'(shifted)) : (EW'(acc) + EW'(shifted));
        sat = 1'b0;
        sum = VW'(total);
        if (total > SMAX)
        begin
            sum = VW'(SMAX);
            sat = 1'b1;
        end
        else if (total < SMIN)
        begin
            sum = VW'(SMIN);
            sat = 1'b1;
        end
    end

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    csc_pkg::item_t     item;
    logic               done;
    csc_pkg::result_t   result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    csc_sparse_matrix_vector_multiply i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [12:0]        col_start [0:256];
    logic [8:0]         row_of    [0:4095];
    logic signed [31:0] entry_val [0:4095];
    logic signed [31:0] vec       [0:255];
    logic signed [31:0] sums      [0:255];
    bit                 sat_flag;
    int                 cfg_rows;
    int                 cfg_cols;
    int                 cfg_off;
    bit                 cfg_tr;
    bit                 cfg_sub;

    // stimulus side view
    int                 gen_ptr [0:256];
    bit                 vec_set [0:255];
    int                 g_rows;
    int                 g_cols;
    int                 g_off;
    bit                 g_tr;

    csc_pkg::item_t     pending_items [$];
    csc_pkg::result_t   expected_results [$];
    int                 idle_pct;
    int                 errors;
    int                 n_items;
    int                 n_sent;
    bit                 took;

    function automatic void add_product(int tgt, longint prod);
        longint s;
        s = sums[tgt];
        s = cfg_sub ? s - prod : s + prod;
        if (s > 64'sd2147483647)
        begin
            s = 64'sd2147483647;
            sat_flag = 1;
        end
        if (s < -64'sd2147483648)
        begin
            s = -64'sd2147483648;
            sat_flag = 1;
        end
        sums[tgt] = s[31:0];
    endfunction

    function automatic void run_matrix();
        int     nr;
        int     nc;
        int     r;
        longint st;
        longint en;
        longint prod;
        nr = cfg_rows > 256 ? 256 : cfg_rows;
        nc = cfg_cols > 256 ? 256 : cfg_cols;
        for (int c = 0; c < nc; c++)
        begin
            st = longint'(col_start[c]) - cfg_off;
            en = longint'(col_start[c + 1]) - cfg_off;
            if (st < 0)
                st = 0;
            if (en > 4096)
                en = 4096;
            for (longint k = st; k < en; k++)
            begin
                r = int'(row_of[k]) - cfg_off;
                if (r < 0 || r >= nr)
                    continue;
                if (cfg_tr)
                    prod = (longint'(entry_val[k]) * longint'(vec[r])) >>> 16;
                else
                    prod = (longint'(entry_val[k]) * longint'(vec[c])) >>> 16;
                add_product(cfg_tr ? c : r, prod);
            end
        end
    endfunction

    function automatic csc_pkg::result_t predict_result(csc_pkg::item_t it);
        csc_pkg::result_t r;
        r = '0;
        case (it.op)
            csc_pkg::OP_COLUMN:
                if (it.slot <= 256)
                    col_start[it.slot] = it.pointer_value;
                else
                    r.status = 1;
            csc_pkg::OP_ENTRY:
            begin
                row_of[it.slot]    = it.row_number;
                entry_val[it.slot] = it.data_value;
            end
            csc_pkg::OP_VECTOR:
                if (it.slot < 256)
                    vec[it.slot] = it.data_value;
                else
                    r.status = 1;
            csc_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < 256; i++)
                    sums[i] = '0;
                sat_flag = 0;
            end
            csc_pkg::OP_RUN:
                run_matrix();
            csc_pkg::OP_READ:
                if (it.slot < 256)
                    r.read_value = sums[it.slot];
                else
                    r.status = 1;
            default:
                ;
        endcase
        r.saturated = sat_flag;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        took <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            expected_results.push_back(predict_result(item));
            n_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (n_sent < 300)
            idle_pct = 16;
        else if (n_sent < 600)
            idle_pct = 72;
        else
            idle_pct = 0;
        if (!start || took)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                item  <= pending_items.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        csc_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: %h", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.read_value !== want.read_value || result.status !== want.status
                    || result.saturated !== want.saturated)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: value %h/%h status %b/%b sat %b/%b",
                                 want.read_value, result.read_value, want.status,
                                 result.status, want.saturated, result.saturated);
                end
            end
        end
    end

    task automatic push(logic [2:0] op, int slot, int ptr, int row, logic [31:0] data);
        csc_pkg::item_t it;
        it.op            = op;
        it.slot          = slot[11:0];
        it.pointer_value = (op == csc_pkg::OP_COLUMN) ? ptr[12:0] : 13'($urandom);
        it.row_number    = (op == csc_pkg::OP_ENTRY) ? row[8:0] : 9'($urandom);
        it.data_value    = (op == csc_pkg::OP_ENTRY || op == csc_pkg::OP_VECTOR) ? data
                                                                                 : $urandom;
        pending_items.push_back(it);
        n_items++;
        if (op == csc_pkg::OP_COLUMN && slot <= 256)
            gen_ptr[slot] = ptr;
        if (op == csc_pkg::OP_VECTOR && slot < 256)
            vec_set[slot] = 1;
    endtask

    task automatic write_reg(logic [2:0] idx, int v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            csc_pkg::REG_NUM_ROWS:     cfg_rows = v & 9'h1ff;
            csc_pkg::REG_NUM_COLUMNS:  cfg_cols = v & 9'h1ff;
            csc_pkg::REG_INDEX_OFFSET: cfg_off  = v & 1;
            csc_pkg::REG_TRANSPOSE:    cfg_tr   = v[0];
            csc_pkg::REG_SUBTRACT:     cfg_sub  = v[0];
            default:                   ;
        endcase
    endtask

    task automatic configure(int nr, int nc, int off, bit tr, bit sub);
        write_reg(csc_pkg::REG_NUM_ROWS, nr);
        write_reg(csc_pkg::REG_NUM_COLUMNS, nc);
        write_reg(csc_pkg::REG_INDEX_OFFSET, off);
        write_reg(csc_pkg::REG_TRANSPOSE, tr);
        write_reg(csc_pkg::REG_SUBTRACT, sub);
        g_rows = nr > 256 ? 256 : nr;
        g_cols = nc > 256 ? 256 : nc;
        g_off  = off;
        g_tr   = tr;
    endtask

    task automatic settle();
        while (pending_items.size() > 0 || expected_results.size() > 0 || start || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h200000) - 32'h100000;
        endcase
    endfunction

    task automatic build_sequence();
        int cur;
        int nxt;
        int st;
        int en;
        int top;
        if (g_cols == 1 && $urandom_range(2) == 0)
        begin
            // end pointer beyond the entry store
            push(csc_pkg::OP_COLUMN, 0, 4093 + g_off, 0, 0);
            push(csc_pkg::OP_COLUMN, 1, 4097, 0, 0);
        end
        else
        begin
            cur = (g_off == 1 && $urandom_range(1)) ? 0 : g_off;
            push(csc_pkg::OP_COLUMN, 0, cur, 0, 0);
            for (int c = 1; c <= g_cols; c++)
            begin
                if ($urandom_range(9) == 0)
                    nxt = cur - $urandom_range(0, cur);
                else if (g_cols > 32)
                    nxt = cur + ($urandom_range(15) == 0);
                else
                    nxt = cur + $urandom_range(0, 4);
                push(csc_pkg::OP_COLUMN, c, nxt, 0, 0);
                cur = nxt;
            end
        end
        for (int c = 0; c < g_cols; c++)
        begin
            st = gen_ptr[c] - g_off;
            en = gen_ptr[c + 1] - g_off;
            if (st < 0)
                st = 0;
            if (en > 4096)
                en = 4096;
            for (int k = st; k < en; k++)
                push(csc_pkg::OP_ENTRY, k, 0,
                     (g_rows == 0 || $urandom_range(7) == 0) ? $urandom_range(0, 256)
                         : $urandom_range(g_off, g_rows - 1 + g_off),
                     pick_value());
        end
        top = g_rows > g_cols ? g_rows : g_cols;
        for (int i = 0; i < top; i++)
            if (!vec_set[i] || $urandom_range(3) == 0)
                push(csc_pkg::OP_VECTOR, i, 0, 0, pick_value());
        if ($urandom_range(1))
            push(csc_pkg::OP_CLEAR, $urandom, 0, 0, 0);
        repeat ($urandom_range(1, 2))
            push(csc_pkg::OP_RUN, $urandom, 0, 0, 0);
        repeat ($urandom_range(1, 4))
            push(csc_pkg::OP_READ, $urandom_range(5) == 0 ? $urandom_range(256, 4095)
                 : $urandom_range(0, top > 0 ? top - 1 : 0), 0, 0, 0);
        repeat ($urandom_range(0, 3))
            case ($urandom_range(4))
                0: push(3'd6 + 3'($urandom_range(1)), $urandom, 0, 0, 0);
                1: push(csc_pkg::OP_COLUMN, $urandom_range(257, 4095), $urandom, 0, 0);
                2: push(csc_pkg::OP_VECTOR, $urandom_range(256, 4095), 0, 0, $urandom);
                3: push(csc_pkg::OP_READ, $urandom, 0, 0, 0);
                default: push(csc_pkg::OP_CLEAR, $urandom, 0, 0, 0);
            endcase
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int p;
        int nr;
        int nc;
        rst_n    = 0;
        start    = 0;
        item     = '0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        errors   = 0;
        n_items  = 0;
        n_sent   = 0;
        idle_pct = 16;
        sat_flag = 0;
        cfg_rows = 256;
        cfg_cols = 256;
        cfg_off  = 0;
        cfg_tr   = 0;
        cfg_sub  = 0;
        for (int i = 0; i < 4096; i++)
        begin
            row_of[i]    = '0;
            entry_val[i] = '0;
        end
        for (int i = 0; i < 256; i++)
        begin
            vec[i]     = '0;
            sums[i]    = '0;
            vec_set[i] = 0;
        end
        for (int i = 0; i <= 256; i++)
        begin
            col_start[i] = '0;
            gen_ptr[i]   = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        settle();

        // directed
        configure(2, 2, 0, 0, 0);
        push(csc_pkg::OP_COLUMN, 0, 0, 0, 0);
        push(csc_pkg::OP_COLUMN, 1, 2, 0, 0);
        push(csc_pkg::OP_COLUMN, 2, 3, 0, 0);
        push(csc_pkg::OP_COLUMN, 4095, 4097, 0, 0);
        push(csc_pkg::OP_ENTRY, 0, 0, 0, 32'h7fffffff);
        push(csc_pkg::OP_ENTRY, 1, 0, 1, 32'h80000000);
        push(csc_pkg::OP_ENTRY, 2, 0, 256, 32'hffffffff);
        push(csc_pkg::OP_ENTRY, 4095, 0, 1, 32'h00010000);
        push(csc_pkg::OP_VECTOR, 0, 0, 0, 32'h7fffffff);
        push(csc_pkg::OP_VECTOR, 1, 0, 0, 32'h80000000);
        push(csc_pkg::OP_VECTOR, 4095, 0, 0, 32'h1);
        push(csc_pkg::OP_RUN, 0, 0, 0, 0);
        push(csc_pkg::OP_READ, 0, 0, 0, 0);
        push(csc_pkg::OP_READ, 1, 0, 0, 0);
        push(csc_pkg::OP_READ, 4095, 0, 0, 0);
        push(3'd6, 0, 0, 0, 0);
        push(3'd7, 4095, 0, 0, 0);
        push(csc_pkg::OP_CLEAR, 4095, 0, 0, 0);
        push(csc_pkg::OP_READ, 0, 0, 0, 0);
        push(csc_pkg::OP_VECTOR, 0, 0, 0, 32'h00008000);
        push(csc_pkg::OP_RUN, 0, 0, 0, 0);
        push(csc_pkg::OP_READ, 1, 0, 0, 0);
        settle();

        p = 0;
        while (n_items < 820)
        begin
            nr = $urandom_range(1, 12);
            nc = $urandom_range(1, 12);
            case (p)
                0:       configure(256, 256, 1, 0, 0);
                1:       configure(0, nc, 0, 1, 1);
                2:       configure(511, 3, 1, 1, 0);
                3:       configure(5, 1, 1, 0, 1);
                4:       configure(3, 0, 0, 0, 0);
                default: configure(nr, nc, $urandom_range(1), $urandom_range(1),
                                   $urandom_range(1));
            endcase
            repeat (g_cols > 32 ? 1 : 2)
                build_sequence();
            settle();
            p++;
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/csc_pkg.sv
rtl/csc_ram.sv
rtl/csc_mac.sv
rtl/csc_sparse_matrix_vector_multiply.sv
dv/tb.sv
